FILE: rtl/delta_offset_table_top_macros.svh
// assertion helpers for delta_offset_table_top
`ifndef DELTA_OFFSET_TABLE_TOP_MACROS_SVH
`define DELTA_OFFSET_TABLE_TOP_MACROS_SVH

// checked only outside reset
`define DOT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define DOT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/dot_pkg.sv
package dot_pkg;

   localparam int OFFSET_W  = 20;
   localparam int ENTRY_W   = 13;
   localparam int GAP_W     = 8;
   localparam int DEPTH_DEF = 4096;

   localparam logic [GAP_W-1:0] GAP_MAX = 8'd255;

   // actions
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_LOAD   = 2'd1;
   localparam logic [1:0] ACT_LOOKUP = 2'd2;

   // table modes
   localparam logic [1:0] TBL_EMPTY = 2'd0;
   localparam logic [1:0] TBL_IDENT = 2'd1;
   localparam logic [1:0] TBL_DELTA = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]          action;
      logic [OFFSET_W-1:0] value;
      logic                is_last;
      logic [OFFSET_W-1:0] buffer_length;
   } dot_req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic [ENTRY_W-1:0]  entry_count;
      logic [1:0]          table_mode;
      logic [1:0]          error;
   } dot_rsp_type;

   typedef struct packed {
      logic busy;
      logic res_valid;
   } dot_stat_type;

endpackage

FILE: rtl/dot_engine.sv
module dot_engine #(
   parameter int DEPTH = dot_pkg::DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dot_pkg::dot_req_type req,
   output logic                 res_valid,
   input  logic                 res_take,
   output dot_pkg::dot_rsp_type res,
   output dot_pkg::dot_stat_type stat
);
   import dot_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_GAP2, S_SUM} state_type;

   // gap memory, one write and one registered read a cycle
   logic [GAP_W-1:0] gap_mem [DEPTH];
   logic [GAP_W-1:0] rd_data_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [GAP_W-1:0] wr_gap;
   logic [IDX_W-1:0] rd_addr;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [1:0]          mode_ff, mode_in;
   logic [OFFSET_W-1:0] prev_ff, prev_in;
   logic                open_ff, open_in;
   logic                res_valid_ff, res_valid_in;
   dot_rsp_type         res_ff, res_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    num_ff, num_in;
   logic                pend_ff, pend_in;
   logic [OFFSET_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]    wr2_addr_ff, wr2_addr_in;
   logic [GAP_W-1:0]    wr2_gap_ff, wr2_gap_in;

   logic                accept;
   logic                res_free;
   logic                push;
   logic [1:0]          err_v;
   logic [OFFSET_W-1:0] byte_v;
   logic [CNT_W-1:0]    cnt0;
   logic [CNT_W-1:0]    cnt1;
   logic [OFFSET_W-1:0] prev1;
   logic                full;
   logic [OFFSET_W:0]   sum_w;

   function automatic logic [GAP_W-1:0] make_gap(input logic [OFFSET_W-1:0] from_v,
                                                 input logic [OFFSET_W-1:0] to_v);
      logic [OFFSET_W-1:0] d;
      d = to_v - from_v;
      if (to_v < from_v) begin
         return '0;
      end else if (d > OFFSET_W'(GAP_MAX)) begin
         return GAP_MAX;
      end else begin
         return d[GAP_W-1:0];
      end
   endfunction

   assign res_free  = !res_valid_ff || res_take;
   assign req_stall = !((state_ff == S_IDLE) && res_free);
   assign accept    = req_valid && !req_stall;
   assign rd_addr   = idx_ff[IDX_W-1:0];
   assign sum_w     = {1'b0, acc_ff} + {{(OFFSET_W + 1 - GAP_W){1'b0}}, rd_data_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mode_in      = mode_ff;
      prev_in      = prev_ff;
      open_in      = open_ff;
      res_valid_in = res_valid_ff && !res_take;
      res_in       = res_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      pend_in      = pend_ff;
      acc_in       = acc_ff;
      wr2_addr_in  = wr2_addr_ff;
      wr2_gap_in   = wr2_gap_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_gap       = '0;
      push         = 1'b0;
      err_v        = ERR_NONE;
      byte_v       = '0;
      cnt0         = '0;
      cnt1         = '0;
      prev1        = prev_ff;
      full         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               push = 1'b1;
               unique case (req.action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     mode_in  = TBL_EMPTY;
                     prev_in  = '0;
                     open_in  = 1'b0;
                  end
                  ACT_LOAD: begin
                     cnt0    = open_ff ? count_ff : '0;
                     full    = (32'(cnt0) >= DEPTH);
                     cnt1    = cnt0;
                     open_in = 1'b1;
                     mode_in = TBL_EMPTY;
                     if (full) begin
                        err_v = ERR_FULL;
                     end else begin
                        if (cnt0 != '0) begin
                           wr_en   = 1'b1;
                           wr_addr = IDX_W'(cnt0 - 1'b1);
                           wr_gap  = make_gap(prev_ff, req.value);
                        end
                        prev1 = req.value;
                        cnt1  = cnt0 + 1'b1;
                     end
                     prev_in  = prev1;
                     count_in = cnt1;
                     if (req.is_last) begin
                        open_in = 1'b0;
                        mode_in = (32'(req.buffer_length) == 32'(cnt1)) ?
                                  TBL_IDENT : TBL_DELTA;
                        if (wr_en) begin
                           // port busy this cycle: final gap goes next cycle
                           wr2_addr_in = IDX_W'(cnt1 - 1'b1);
                           wr2_gap_in  = make_gap(prev1, req.buffer_length);
                           state_in    = S_GAP2;
                        end else begin
                           wr_en   = 1'b1;
                           wr_addr = IDX_W'(cnt1 - 1'b1);
                           wr_gap  = make_gap(prev1, req.buffer_length);
                        end
                     end
                  end
                  ACT_LOOKUP: begin
                     if (32'(req.value) > 32'(count_ff)) begin
                        err_v = ERR_RANGE;
                     end else if (mode_ff == TBL_IDENT) begin
                        byte_v = req.value;
                     end else if ((mode_ff == TBL_DELTA) && (req.value != '0)) begin
                        push     = 1'b0;
                        num_in   = CNT_W'(req.value);
                        idx_in   = '0;
                        pend_in  = 1'b0;
                        acc_in   = '0;
                        state_in = S_SUM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_GAP2: begin
            wr_en    = 1'b1;
            wr_addr  = wr2_addr_ff;
            wr_gap   = wr2_gap_ff;
            state_in = S_IDLE;
         end
         S_SUM: begin
            pend_in = (idx_ff != num_ff);
            if (idx_ff != num_ff) begin
               idx_in = idx_ff + 1'b1;
            end
            if (pend_ff) begin
               acc_in = sum_w[OFFSET_W] ? '1 : sum_w[OFFSET_W-1:0];
            end
            if (!pend_ff && (idx_ff == num_ff) && res_free) begin
               push     = 1'b1;
               byte_v   = acc_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (push) begin
         res_valid_in       = 1'b1;
         res_in.byte_offset = byte_v;
         res_in.entry_count = ENTRY_W'(32'(count_in));
         res_in.table_mode  = mode_in;
         res_in.error       = err_v;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         gap_mem[wr_addr] <= wr_gap;
      end
      rd_data_ff <= gap_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mode_ff      <= TBL_EMPTY;
         prev_ff      <= '0;
         open_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         prev_ff      <= prev_in;
         open_ff      <= open_in;
         res_valid_ff <= res_valid_in;
         pend_ff      <= pend_in;
      end
      res_ff      <= res_in;
      idx_ff      <= idx_in;
      num_ff      <= num_in;
      acc_ff      <= acc_in;
      wr2_addr_ff <= wr2_addr_in;
      wr2_gap_ff  <= wr2_gap_in;
   end

   assign res_valid      = res_valid_ff;
   assign res            = res_ff;
   assign stat.busy      = (state_ff != S_IDLE);
   assign stat.res_valid = res_valid_ff;

endmodule

FILE: rtl/dot_rsp_stage.sv
module dot_rsp_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  dot_pkg::dot_rsp_type push_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dot_pkg::dot_rsp_type rsp
);
   import dot_pkg::*;

   logic        valid_ff, valid_in;
   dot_rsp_type data_ff, data_in;

   assign push_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (push_valid && push_ready) begin
         valid_in = 1'b1;
         data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

FILE: rtl/delta_offset_table_top.sv
// channel  | ports                       | beat moves on
// ---------+-----------------------------+-------------------------------
// request  | req_valid, req_stall, req   | req_valid high, req_stall low
// response | rsp_valid, rsp_stall, rsp   | rsp_valid high, rsp_stall low
//
// clear, load and non-summing lookups push their result from idle; a final load
// closing a gap writes that gap in S_GAP2, as the gap memory has one write port
// a delta lookup of index n >= 1 walks n gaps, one gap read a cycle
// through the registered read port and added into the running sum
// reset is synchronous and active high; the table comes up empty
// a stalled response waits in the output register with one more held behind it
`include "delta_offset_table_top_macros.svh"

module delta_offset_table_top #(
   parameter int DEPTH = dot_pkg::DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dot_pkg::dot_req_type req,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dot_pkg::dot_rsp_type rsp
);
   import dot_pkg::*;

   // result handed from the engine to the output register
   logic         res_valid;
   logic         res_take;
   dot_rsp_type  res;
   dot_stat_type stat;

   // request beat taken this cycle, and anything still owed by the engine
   logic         req_beat;
   logic         in_flight;

   assign req_beat  = req_valid && !req_stall;
   assign in_flight = stat.res_valid || stat.busy;

   // sequencer and gap memory: loads write gaps, delta lookups walk them
   dot_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .stat      (stat)
   );

   // output register parts the response side from the engine
   dot_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_valid),
      .push_ready (res_take),
      .push_data  (res),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // every accepted beat leaves either a pending result or a running walk
   `DOT_ASSERT(a_accept_tracked, req_beat |=> in_flight, "accepted beat left no trace")
   // no request beat is taken while a walk or a second gap write is running
   `DOT_ASSERT(a_busy_stalls, stat.busy |-> req_stall, "request taken while engine busy")
   // reset leaves nothing in flight
   `DOT_ASSERT_ALWAYS(a_reset_clean, reset |=> (!rsp_valid && !in_flight), "state after reset")

endmodule
